// ===== rtl/tank_level_pump_controller_defines.svh =====
// assertion macros shared by the tank level pump controller rtl
`ifndef TANK_LEVEL_PUMP_CONTROLLER_DEFINES_SVH
`define TANK_LEVEL_PUMP_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TLPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlpc assertion failed");

// next-cycle implication, checked outside reset
`define TLPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlpc assertion failed");

`endif

// ===== rtl/tlpc_pkg.sv =====
// types and constants of the tank level pump controller
package tlpc_pkg;

   localparam int LEVEL_W = 10;
   localparam int TIME_W  = 32;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [TIME_W-1:0]  time_ms_type;

   typedef enum logic [1:0] {
      CSR_LOW_THRESHOLD  = 2'd0,
      CSR_MID_THRESHOLD  = 2'd1,
      CSR_HIGH_THRESHOLD = 2'd2,
      CSR_RUN_LIMIT_MS   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      BAND_NONE   = 2'd0,
      BAND_LOW    = 2'd1,
      BAND_MIDDLE = 2'd2,
      BAND_HIGH   = 2'd3
   } band_type;

   localparam level_type   LOW_THRESHOLD_RST  = 10'd306;
   localparam level_type   MID_THRESHOLD_RST  = 10'd818;
   localparam level_type   HIGH_THRESHOLD_RST = 10'd1023;
   localparam time_ms_type RUN_LIMIT_MS_RST   = 32'd2000;

endpackage

// ===== rtl/tank_level_pump_controller.sv =====
// tank level pump controller: one poll in, one pump/lamp result out
//
// usage:
//   req_* carries one poll (level sample, millisecond timestamp, reset,
//   start/stop and safety inputs); a request is taken on a clock edge with
//   req_valid high and req_stall low.
//   rsp_* returns one result per request (pump drive, band lamp, fault lamp),
//   taken on a clock edge with rsp_valid high and rsp_stall low.
//   csr_* writes one threshold or the run limit per edge with csr_valid and
//   csr_ready high; csr_ready is always high. write only while idle.
// path: a request passes the input register, then the result register; the
//   controller state is updated as the poll enters the result register.
// throughput: one request per cycle while rsp_stall is low, set by the single
//   pass of compares and one 32-bit subtract between the two registers.
// receiver stall: the result register holds; the input register still takes
//   one more request, after which req_stall rises until results drain.
// reset: synchronous, active high; empties both registers, restores the
//   default thresholds and run limit, stops the pump and clears the latch.
`include "tank_level_pump_controller_defines.svh"

module tank_level_pump_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tlpc_pkg::level_type    req_level_sample,
   input  tlpc_pkg::time_ms_type  req_now_ms,
   input  logic                   req_reset_request,
   input  logic                   req_start_stop_request,
   input  logic                   req_safety_trip,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_pump_on,
   output tlpc_pkg::band_type     rsp_level_band,
   output logic                   rsp_fault_active,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  tlpc_pkg::csr_index_type csr_index,
   input  tlpc_pkg::time_ms_type  csr_wdata
);
   import tlpc_pkg::*;

   // configuration
   level_type   low_threshold_ff;
   level_type   mid_threshold_ff;
   level_type   high_threshold_ff;
   time_ms_type run_limit_ms_ff;

   // input register
   logic        in_valid_ff;
   level_type   in_level_ff;
   time_ms_type in_now_ff;
   logic        in_rst_ff;
   logic        in_toggle_ff;
   logic        in_trip_ff;

   // controller state
   logic        running_ff, running_in;
   time_ms_type run_start_ff, run_start_in;
   level_type   last_level_ff, last_level_in;
   logic        last_valid_ff, last_valid_in;
   logic        fault_ff, fault_in;
   band_type    band_ff, band_in;

   // result register
   logic        out_valid_ff;
   logic        out_pump_ff;
   band_type    out_band_ff;
   logic        out_fault_ff;

   logic        advance;
   logic        in_load;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_threshold_ff  <= LOW_THRESHOLD_RST;
         mid_threshold_ff  <= MID_THRESHOLD_RST;
         high_threshold_ff <= HIGH_THRESHOLD_RST;
         run_limit_ms_ff   <= RUN_LIMIT_MS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOW_THRESHOLD:  low_threshold_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_MID_THRESHOLD:  mid_threshold_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_HIGH_THRESHOLD: high_threshold_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_RUN_LIMIT_MS:   run_limit_ms_ff   <= csr_wdata;
            default:            run_limit_ms_ff   <= run_limit_ms_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_level_ff  <= req_level_sample;
         in_now_ff    <= req_now_ms;
         in_rst_ff    <= req_reset_request;
         in_toggle_ff <= req_start_stop_request;
         in_trip_ff   <= req_safety_trip;
      end
   end

   // one poll: latch, toggle, run timeout, then level checks in order
   always_comb begin
      logic        lv_valid;
      logic        run1;
      time_ms_type start1;
      time_ms_type elapsed;
      logic        changed;

      lv_valid = last_valid_ff && !in_rst_ff;
      fault_in = (fault_ff && !in_rst_ff) || in_trip_ff;

      run1   = running_ff;
      start1 = run_start_ff;
      if (in_toggle_ff) begin
         if (running_ff) begin
            run1   = 1'b0;
            start1 = '0;
         end else begin
            run1   = 1'b1;
            start1 = in_now_ff;
         end
      end

      // elapsed time wraps modulo 2^32
      elapsed = in_now_ff - start1;
      if (run1 && (elapsed > run_limit_ms_ff)) begin
         run1   = 1'b0;
         start1 = '0;
      end

      changed       = !lv_valid || (in_level_ff != last_level_ff);
      last_level_in = last_level_ff;
      last_valid_in = lv_valid;
      band_in       = band_ff;
      if (changed) begin
         last_level_in = in_level_ff;
         last_valid_in = 1'b1;
         if (in_level_ff <= low_threshold_ff) begin
            run1   = 1'b1;
            start1 = in_now_ff;
         end
         if (in_level_ff >= high_threshold_ff) begin
            run1   = 1'b0;
            start1 = '0;
         end
         priority if (in_level_ff <= low_threshold_ff) begin
            band_in = BAND_LOW;
         end else if (in_level_ff <= mid_threshold_ff) begin
            band_in = BAND_MIDDLE;
         end else begin
            band_in = BAND_HIGH;
         end
      end

      running_in   = run1;
      run_start_in = start1;

      // latched fault overrides everything but the forgotten level
      if (fault_in) begin
         running_in    = 1'b0;
         run_start_in  = '0;
         band_in       = BAND_NONE;
         last_level_in = last_level_ff;
         last_valid_in = lv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         run_start_ff  <= '0;
         last_level_ff <= '0;
         last_valid_ff <= 1'b0;
         fault_ff      <= 1'b0;
         band_ff       <= BAND_NONE;
      end else if (advance) begin
         running_ff    <= running_in;
         run_start_ff  <= run_start_in;
         last_level_ff <= last_level_in;
         last_valid_ff <= last_valid_in;
         fault_ff      <= fault_in;
         band_ff       <= band_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_pump_ff  <= running_in;
         out_band_ff  <= band_in;
         out_fault_ff <= fault_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pump_on      = out_pump_ff;
   assign rsp_level_band   = out_band_ff;
   assign rsp_fault_active = out_fault_ff;

   `TLPC_ASSERT_IMPL(a_fault_dark, clock, reset, rsp_valid && rsp_fault_active, !rsp_pump_on && (rsp_level_band == BAND_NONE))
   `TLPC_ASSERT_IMPL(a_stopped_no_start, clock, reset, !running_ff, run_start_ff == '0)
   `TLPC_ASSERT_IMPL(a_rsp_matches_state, clock, reset, rsp_valid, (rsp_pump_on == running_ff) && (rsp_fault_active == fault_ff))
   `TLPC_ASSERT_NEXT(a_level_kept, clock, reset, advance && !fault_in, last_valid_ff && rsp_valid)

endmodule
